>>> rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Operation codes shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	typedef enum logic [2:0] {
		MODE_ADD = 3'd0,
		MODE_SUB = 3'd1,
		MODE_MUL = 3'd2,
		MODE_DIV = 3'd3,
		MODE_CMP = 3'd4
	} mode_t;

endpackage

>>> rtl/cau_cdiv.sv
// ----------------------------------------------------------------------------
// cau_cdiv
// Pipelined restoring divider: two numerators over one shared divisor, one
// quotient bit per stage, with an up-front check for quotients that do not
// fit in DATA_WIDTH+1 bits.
// ----------------------------------------------------------------------------
module cau_cdiv #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [2*DATA_WIDTH+FRAC_BITS:0]     num_re,
	input  logic [2*DATA_WIDTH+FRAC_BITS:0]     num_im,
	input  logic [2*DATA_WIDTH:0]               den,
	output logic [DATA_WIDTH:0]                 quo_re,
	output logic [DATA_WIDTH:0]                 quo_im,
	output logic                                big_re,
	output logic                                big_im
);

	localparam int W  = DATA_WIDTH;
	localparam int LW = 2*W + FRAC_BITS + 1;
	localparam int DW = 2*W + 1;
	localparam int QB = W + 1;
	localparam int HW = LW - QB;
	localparam int CW = (HW > DW) ? HW : DW;

	logic [DW-1:0] den_s   [0:QB];
	logic [DW-1:0] rem_re_s [0:QB];
	logic [DW-1:0] rem_im_s [0:QB];
	logic [QB-1:0] lo_re_s  [0:QB];
	logic [QB-1:0] lo_im_s  [0:QB];
	logic [QB-1:0] q_re_s   [0:QB];
	logic [QB-1:0] q_im_s   [0:QB];
	logic          big_re_s [0:QB];
	logic          big_im_s [0:QB];

	logic [HW-1:0] hi_re, hi_im;

	assign hi_re = HW'(num_re >> QB);
	assign hi_im = HW'(num_im >> QB);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]    <= den;
			rem_re_s[0] <= DW'(hi_re);
			rem_im_s[0] <= DW'(hi_im);
			lo_re_s[0]  <= num_re[QB-1:0];
			lo_im_s[0]  <= num_im[QB-1:0];
			q_re_s[0]   <= '0;
			q_im_s[0]   <= '0;
			big_re_s[0] <= CW'(hi_re) >= CW'(den);
			big_im_s[0] <= CW'(hi_im) >= CW'(den);
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [DW:0] t_re, t_im;
		logic        ge_re, ge_im;

		assign t_re  = {rem_re_s[k-1], lo_re_s[k-1][QB-1]};
		assign t_im  = {rem_im_s[k-1], lo_im_s[k-1][QB-1]};
		assign ge_re = t_re >= {1'b0, den_s[k-1]};
		assign ge_im = t_im >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]    <= den_s[k-1];
				rem_re_s[k] <= ge_re ? DW'(t_re - {1'b0, den_s[k-1]}) : DW'(t_re);
				rem_im_s[k] <= ge_im ? DW'(t_im - {1'b0, den_s[k-1]}) : DW'(t_im);
				lo_re_s[k]  <= lo_re_s[k-1] << 1;
				lo_im_s[k]  <= lo_im_s[k-1] << 1;
				q_re_s[k]   <= {q_re_s[k-1][QB-2:0], ge_re};
				q_im_s[k]   <= {q_im_s[k-1][QB-2:0], ge_im};
				big_re_s[k] <= big_re_s[k-1];
				big_im_s[k] <= big_im_s[k-1];
			end
		end
	end

	assign quo_re = q_re_s[QB];
	assign quo_im = q_im_s[QB];
	assign big_re = big_re_s[QB];
	assign big_im = big_im_s[QB];

endmodule

>>> rtl/complex_arith_unit.sv
// Division: the quotient takes one divider stage a bit.
// Throughput: one item per cycle; the whole pipeline holds while the result
//   at the output is not taken.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
// complex_arith_unit
// Saturating fixed-point complex add, subtract, multiply, divide and compare.
// ----------------------------------------------------------------------------
module complex_arith_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   mode,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic                         is_equal,
	output logic                         overflow,
	output logic                         div_zero
);

	localparam int W  = DATA_WIDTH;
	localparam int PW = 2*W;
	localparam int NW = 2*W + 1;
	localparam int MW = 2*W;
	localparam int RW = MW + FRAC_BITS + 1;
	localparam int LW = 2*W + FRAC_BITS + 1;
	localparam int DW = 2*W + 1;
	localparam int QB = W + 1;
	localparam logic [RW-1:0] HALF = (RW'(1) << FRAC_BITS) >> 1;
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		mode_t        mode;
		logic         eq;
		logic         dz;
		logic         neg_re;
		logic         neg_im;
		logic         ov;
		logic [W-1:0] er_re;
		logic [W-1:0] er_im;
	} side_t;

	function automatic logic [W:0] sat_emit(input logic neg, input logic big,
			input logic [MW-1:0] mag);
		logic [MW-1:0] lim;
		logic [MW-1:0] m;
		logic [W-1:0]  mw;
		logic          ov;
		lim = (MW'(1) << (W-1)) - MW'(!neg);
		ov  = big || (mag > lim);
		m   = ov ? lim : mag;
		mw  = m[W-1:0];
		return {ov, neg ? -mw : mw};
	endfunction

	logic adv;

	// stage 1
	logic                 v_s1;
	mode_t                mode_s1;
	logic                 eq_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, p_bb_s1, p_cc_s1;
	logic signed [W:0]    as_re_s1, as_im_s1;
	// stage 2
	logic                 v_s2;
	mode_t                mode_s2;
	logic                 eq_s2;
	logic signed [NW-1:0] nr_s2, ni_s2;
	logic [MW-1:0]        d_s2;
	logic signed [W:0]    as_re_s2, as_im_s2;
	// stage 3
	logic                 v_s3;
	mode_t                mode_s3;
	logic                 eq_s3, dz_s3, neg_re_s3, neg_im_s3, eov_s3;
	logic [MW-1:0]        mag_re_s3, mag_im_s3, d_s3;
	logic [W-1:0]         er_re_s3, er_im_s3;
	// stage 4
	logic                 v_s4;
	mode_t                mode_s4;
	logic                 eq_s4, dz_s4, neg_re_s4, neg_im_s4, eov_s4;
	logic [MW-1:0]        rnd_re_s4, rnd_im_s4;
	logic [LW-1:0]        num_re_s4, num_im_s4;
	logic [DW-1:0]        den_s4;
	logic [W-1:0]         er_re_s4, er_im_s4;
	// stage 5 and divider alignment
	logic                 v_s5;
	side_t                side_s5;
	logic                 v_sd    [1:QB];
	side_t                side_sd [1:QB];
	// output
	logic                 v_q;
	logic signed [W-1:0]  res_re_q, res_im_q;
	logic                 eq_q, ov_q, dz_q;

	logic [W:0]    abs_re, abs_im;
	logic [W:0]    e_re, e_im, m_re, m_im, q_re_e, q_im_e;
	logic [QB-1:0] quo_re, quo_im;
	logic          big_re, big_im;
	side_t         side_n, side_o;

	assign adv      = !v_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 1; k <= QB; k++) v_sd[k] <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_sd[1] <= v_s5;
			for (int k = 2; k <= QB; k++) v_sd[k] <= v_sd[k-1];
			v_q  <= v_sd[QB];
		end
	end

	// products and sums
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode_t'(mode);
			eq_s1   <= (a_re == b_re) && (a_im == b_im);
			p_rr_s1 <= PW'(a_re) * PW'(b_re);
			p_ii_s1 <= PW'(a_im) * PW'(b_im);
			p_ir_s1 <= PW'(a_im) * PW'(b_re);
			p_ri_s1 <= PW'(a_re) * PW'(b_im);
			p_bb_s1 <= PW'(b_re) * PW'(b_re);
			p_cc_s1 <= PW'(b_im) * PW'(b_im);
			if (mode_t'(mode) == MODE_SUB) begin
				as_re_s1 <= (W+1)'(a_re) - (W+1)'(b_re);
				as_im_s1 <= (W+1)'(a_im) - (W+1)'(b_im);
			end else begin
				as_re_s1 <= (W+1)'(a_re) + (W+1)'(b_re);
				as_im_s1 <= (W+1)'(a_im) + (W+1)'(b_im);
			end
		end
	end

	// combine products
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2  <= mode_s1;
			eq_s2    <= eq_s1;
			as_re_s2 <= as_re_s1;
			as_im_s2 <= as_im_s1;
			d_s2     <= MW'($unsigned(p_bb_s1)) + MW'($unsigned(p_cc_s1));
			if (mode_s1 == MODE_MUL) begin
				nr_s2 <= NW'(p_rr_s1) - NW'(p_ii_s1);
				ni_s2 <= NW'(p_ir_s1) + NW'(p_ri_s1);
			end else begin
				nr_s2 <= NW'(p_rr_s1) + NW'(p_ii_s1);
				ni_s2 <= NW'(p_ir_s1) - NW'(p_ri_s1);
			end
		end
	end

	always_comb begin
		abs_re = as_re_s2[W] ? -$unsigned(as_re_s2) : $unsigned(as_re_s2);
		abs_im = as_im_s2[W] ? -$unsigned(as_im_s2) : $unsigned(as_im_s2);
		e_re   = sat_emit(as_re_s2[W], 1'b0, MW'(abs_re));
		e_im   = sat_emit(as_im_s2[W], 1'b0, MW'(abs_im));
	end

	// sign and magnitude, add/subtract results
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3   <= mode_s2;
			eq_s3     <= eq_s2;
			d_s3      <= d_s2;
			dz_s3     <= d_s2 == '0;
			neg_re_s3 <= nr_s2[NW-1];
			neg_im_s3 <= ni_s2[NW-1];
			mag_re_s3 <= MW'(nr_s2[NW-1] ? -nr_s2 : nr_s2);
			mag_im_s3 <= MW'(ni_s2[NW-1] ? -ni_s2 : ni_s2);
			er_re_s3  <= e_re[W-1:0];
			er_im_s3  <= e_im[W-1:0];
			eov_s3    <= e_re[W] | e_im[W];
		end
	end

	// round products, build dividends
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s4   <= mode_s3;
			eq_s4     <= eq_s3;
			dz_s4     <= dz_s3;
			neg_re_s4 <= neg_re_s3;
			neg_im_s4 <= neg_im_s3;
			er_re_s4  <= er_re_s3;
			er_im_s4  <= er_im_s3;
			eov_s4    <= eov_s3;
			rnd_re_s4 <= MW'((RW'(mag_re_s3) + HALF) >> FRAC_BITS);
			rnd_im_s4 <= MW'((RW'(mag_im_s3) + HALF) >> FRAC_BITS);
			num_re_s4 <= (LW'(mag_re_s3) << (FRAC_BITS + 1)) + LW'(d_s3);
			num_im_s4 <= (LW'(mag_im_s3) << (FRAC_BITS + 1)) + LW'(d_s3);
			den_s4    <= {d_s3, 1'b0};
		end
	end

	always_comb begin
		m_re = sat_emit(neg_re_s4, 1'b0, rnd_re_s4);
		m_im = sat_emit(neg_im_s4, 1'b0, rnd_im_s4);
		side_n        = '0;
		side_n.mode   = mode_s4;
		side_n.eq     = eq_s4;
		side_n.dz     = dz_s4;
		side_n.neg_re = neg_re_s4;
		side_n.neg_im = neg_im_s4;
		case (mode_s4)
			MODE_ADD, MODE_SUB: begin
				side_n.er_re = er_re_s4;
				side_n.er_im = er_im_s4;
				side_n.ov    = eov_s4;
			end
			MODE_MUL: begin
				side_n.er_re = m_re[W-1:0];
				side_n.er_im = m_im[W-1:0];
				side_n.ov    = m_re[W] | m_im[W];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5    <= side_n;
			side_sd[1] <= side_s5;
			for (int k = 2; k <= QB; k++) side_sd[k] <= side_sd[k-1];
		end
	end

	cau_cdiv #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.en     (adv),
		.num_re (num_re_s4),
		.num_im (num_im_s4),
		.den    (den_s4),
		.quo_re (quo_re),
		.quo_im (quo_im),
		.big_re (big_re),
		.big_im (big_im)
	);

	always_comb begin
		side_o = side_sd[QB];
		q_re_e = sat_emit(side_o.neg_re, big_re, MW'(quo_re));
		q_im_e = sat_emit(side_o.neg_im, big_im, MW'(quo_im));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eq_q <= side_o.eq;
			if (side_o.mode == MODE_DIV) begin
				dz_q <= side_o.dz;
				if (side_o.dz) begin
					res_re_q <= '0;
					res_im_q <= '0;
					ov_q     <= 1'b0;
				end else begin
					res_re_q <= q_re_e[W-1:0];
					res_im_q <= q_im_e[W-1:0];
					ov_q     <= q_re_e[W] | q_im_e[W];
				end
			end else begin
				dz_q     <= 1'b0;
				res_re_q <= side_o.er_re;
				res_im_q <= side_o.er_im;
				ov_q     <= side_o.ov;
			end
		end
	end

	assign out_valid = v_q;
	assign res_re    = res_re_q;
	assign res_im    = res_im_q;
	assign is_equal  = eq_q;
	assign overflow  = ov_q;
	assign div_zero  = dz_q;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> res_re == '0 && res_im == '0 && !overflow)
		else $error("divide by zero with nonzero result");

	a_ov_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> res_re == SMAX || res_re == SMIN ||
			res_im == SMAX || res_im == SMIN)
		else $error("overflow without a saturated part");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held while output free");

endmodule

>>> tb/sv/complex_arith_unit_test.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_test
// Drives operand items through the complex arithmetic unit under several
// idle and stall patterns and checks each result against a predictor.
// ----------------------------------------------------------------------------
module complex_arith_unit_test import cau_pkg::*; ();

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [2:0] MODE_RSVD_FIRST = 3'd5;
	localparam logic [2:0] MODE_RSVD_LAST = 3'd7;
	localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] ONE = 1 <<< FB;

	typedef struct {
		logic [2:0] mode;
		logic signed [DW-1:0] ar, ai, br, bi;
	} operands_t;

	typedef struct {
		logic signed [DW-1:0] re, im;
		logic eq, ov, dz;
	} cplx_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] mode = MODE_ADD;
	logic signed [DW-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DW-1:0] res_re, res_im;
	logic is_equal, overflow, div_zero;

	cplx_result_t pending_results[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int sink_stall_pct = 0;

	complex_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic signed [DW-1:0] saturate(input logic signed [127:0] v,
			inout logic ov);
		if (v > 128'sd0 + VMAX) begin
			ov = 1'b1;
			return VMAX;
		end
		if (v < 128'sd0 + VMIN) begin
			ov = 1'b1;
			return VMIN;
		end
		return v[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] round_product(input logic signed [127:0] s,
			inout logic ov);
		logic signed [127:0] mag;
		mag = s < 0 ? -s : s;
		if (FB > 0) mag = (mag + (128'sd1 <<< (FB - 1))) >>> FB;
		return saturate(s < 0 ? -mag : mag, ov);
	endfunction

	function automatic logic signed [DW-1:0] round_quotient(input logic signed [127:0] n,
			input logic signed [127:0] d, inout logic ov);
		logic [127:0] mag;
		mag = n < 0 ? -n : n;
		mag = ((mag << (FB + 1)) + d) / (d << 1);
		return saturate(n < 0 ? -$signed(mag) : $signed(mag), ov);
	endfunction

	function automatic cplx_result_t predict_complex(input operands_t op);
		cplx_result_t r;
		logic signed [127:0] ar, ai, br, bi, d;
		ar = op.ar; ai = op.ai; br = op.br; bi = op.bi;
		r = '{re: '0, im: '0, eq: 1'b0, ov: 1'b0, dz: 1'b0};
		r.eq = (op.ar == op.br) && (op.ai == op.bi);
		case (op.mode)
			MODE_ADD: begin
				r.re = saturate(ar + br, r.ov);
				r.im = saturate(ai + bi, r.ov);
			end
			MODE_SUB: begin
				r.re = saturate(ar - br, r.ov);
				r.im = saturate(ai - bi, r.ov);
			end
			MODE_MUL: begin
				r.re = round_product(ar * br - ai * bi, r.ov);
				r.im = round_product(ai * br + ar * bi, r.ov);
			end
			MODE_DIV: begin
				d = br * br + bi * bi;
				if (d == 0) r.dz = 1'b1;
				else begin
					r.re = round_quotient(ar * br + ai * bi, d, r.ov);
					r.im = round_quotient(ai * br - ar * bi, d, r.ov);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(input operands_t op);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = op.mode;
		a_re = op.ar; a_im = op.ai; b_re = op.br; b_im = op.bi;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_complex(op));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	always @(negedge clk) out_ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		cplx_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result re=%h im=%h", $time, res_re, res_im);
			end else begin
				exp_r = pending_results.pop_front();
				if (res_re !== exp_r.re || res_im !== exp_r.im || is_equal !== exp_r.eq
						|| overflow !== exp_r.ov || div_zero !== exp_r.dz) begin
					errors++;
					$display("%0t: expected re=%h im=%h eq=%b ov=%b dz=%b", $time,
						exp_r.re, exp_r.im, exp_r.eq, exp_r.ov, exp_r.dz);
					$display("%0t:   actual re=%h im=%h eq=%b ov=%b dz=%b", $time,
						res_re, res_im, is_equal, overflow, div_zero);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic signed [DW-1:0] pick_part();
		case ($urandom_range(5))
			0: return $urandom;
			1: case ($urandom_range(3))
				0: return VMAX;
				1: return VMIN;
				2: return '0;
				default: return -1;
			endcase
			2: return $signed($urandom_range(1 << 20)) * ($urandom_range(1) ? 1 : -1);
			3: return ONE * $signed($urandom_range(8)) * ($urandom_range(1) ? 1 : -1)
				+ $signed($urandom_range(255)) - 128;
			4: return $signed($urandom_range(3)) - 1;
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	function automatic operands_t random_item();
		operands_t op;
		op.mode = ($urandom_range(9) == 0)
			? 3'($urandom_range(MODE_RSVD_LAST, MODE_RSVD_FIRST))
			: 3'($urandom_range(MODE_CMP, MODE_ADD));
		op.ar = pick_part(); op.ai = pick_part();
		op.br = pick_part(); op.bi = pick_part();
		case ($urandom_range(9))
			0: begin op.br = op.ar; op.bi = op.ai; end
			1: begin op.br = '0; op.bi = '0; end
			default: ;
		endcase
		return op;
	endfunction

	task automatic test_extremes();
		operands_t list[$];
		list = '{
			'{MODE_ADD, VMAX, VMIN, VMAX, VMIN},
			'{MODE_ADD, VMAX, 1, VMIN, -1},
			'{MODE_SUB, VMIN, VMAX, VMAX, VMIN},
			'{MODE_SUB, 0, -1, VMIN, VMAX},
			'{MODE_MUL, VMAX, VMAX, VMAX, VMAX},
			'{MODE_MUL, VMIN, VMIN, VMIN, VMIN},
			'{MODE_MUL, 1, 0, 32'sh8000, 0},
			'{MODE_MUL, -1, 0, 32'sh8000, 0},
			'{MODE_MUL, ONE, ONE, -ONE, ONE},
			'{MODE_DIV, ONE, ONE, 0, 0},
			'{MODE_DIV, VMIN, VMAX, ONE, 0},
			'{MODE_DIV, VMAX, VMIN, 1, 0},
			'{MODE_DIV, ONE, 0, 0, VMIN},
			'{MODE_DIV, 1, 1, 3, 0},
			'{MODE_DIV, -ONE, ONE, 3 * ONE, -ONE},
			'{MODE_CMP, VMAX, VMIN, VMAX, VMIN},
			'{MODE_CMP, VMAX, VMIN, VMAX, VMAX},
			'{MODE_RSVD_FIRST, 5, 7, 5, 7},
			'{MODE_RSVD_LAST, -1, 0, VMIN, 0},
			'{MODE_ADD, -1, -1, -1, -1}
		};
		foreach (list[i]) send_item(list[i]);
		wait_drained();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		repeat (count) send_item(random_item());
		wait_drained();
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_random_phase(0, 0, 250);
		test_random_phase(80, 0, 150);
		test_random_phase(0, 80, 150);
		test_random_phase(20, 20, 250);
		send_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
